@@ hdl/efv_pkg.sv @@
package efv_pkg;

  localparam int TAP_COUNT     = 9;
  localparam int COUNT_BITS    = 24;
  localparam int COEF_BITS     = 13;
  localparam int SUM_BITS      = COUNT_BITS + COEF_BITS;
  localparam int SCALE_BITS    = 32;
  localparam int HALF_BITS     = SCALE_BITS / 2;
  localparam int FRAC_BITS     = 16;
  localparam int POS_BITS      = COUNT_BITS + FRAC_BITS;
  localparam int VEL_BITS      = SUM_BITS + FRAC_BITS;
  localparam int POS_PROD_BITS = COUNT_BITS + SCALE_BITS + 1;
  localparam int VEL_PROD_BITS = SUM_BITS + HALF_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POSITION_SCALE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VELOCITY_SCALE = 2'd1;

  localparam logic signed [COEF_BITS-1:0] TAP_COEF [TAP_COUNT] = '{
    13'sd2727, 13'sd534, -13'sd2658, -13'sd795, 13'sd72,
    13'sd110, 13'sd19, -13'sd6, -13'sd3
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctrl_t;

endpackage

@@ hdl/efv_cell.sv @@
module efv_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  efv_pkg::cell_ctrl_t                   ctrl_i,
  input  logic signed [efv_pkg::COUNT_BITS-1:0] count_i,
  input  logic signed [efv_pkg::COUNT_BITS-1:0] left_i,
  input  logic signed [efv_pkg::COEF_BITS-1:0]  coef_i,
  input  logic                                  tok_i,
  input  logic signed [efv_pkg::SUM_BITS-1:0]   psum_i,
  output logic signed [efv_pkg::COUNT_BITS-1:0] value_o,
  output logic                                  tok_o,
  output logic signed [efv_pkg::SUM_BITS-1:0]   psum_o
);
  import efv_pkg::*;

  logic signed [COUNT_BITS-1:0] value_q, value_d;
  logic                         tok_q;
  logic signed [SUM_BITS-1:0]   psum_q, psum_d;
  logic signed [SUM_BITS-1:0]   prod;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = ctrl_i.fill ? count_i : left_i;
    end
  end

  assign prod   = SUM_BITS'(value_q) * SUM_BITS'(coef_i);
  assign psum_d = psum_i + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      value_q <= value_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      psum_q <= psum_d;
    end
  end

  assign value_o = value_q;
  assign tok_o   = tok_q;
  assign psum_o  = psum_q;

endmodule

@@ hdl/efv_scale.sv @@
module efv_scale (
  input  logic                                  clk_i,
  input  logic                                  mul_en_i,
  input  logic signed [efv_pkg::COUNT_BITS-1:0] count_i,
  input  logic signed [efv_pkg::SUM_BITS-1:0]   sum_i,
  input  logic [efv_pkg::SCALE_BITS-1:0]        position_scale_i,
  input  logic [efv_pkg::SCALE_BITS-1:0]        velocity_scale_i,
  output logic signed [efv_pkg::POS_BITS-1:0]   position_o,
  output logic signed [efv_pkg::VEL_BITS-1:0]   velocity_o
);
  import efv_pkg::*;

  logic signed [POS_PROD_BITS-1:0] pos_prod_q;
  logic signed [VEL_PROD_BITS-1:0] vel_hi_q;
  logic signed [VEL_PROD_BITS-1:0] vel_lo_q;
  logic signed [VEL_PROD_BITS-1:0] vel_full;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      pos_prod_q <= POS_PROD_BITS'(count_i)
                    * POS_PROD_BITS'($signed({1'b0, position_scale_i}));
      vel_hi_q   <= VEL_PROD_BITS'(sum_i)
                    * VEL_PROD_BITS'($signed({1'b0, velocity_scale_i[SCALE_BITS-1:HALF_BITS]}));
      vel_lo_q   <= VEL_PROD_BITS'(sum_i)
                    * VEL_PROD_BITS'($signed({1'b0, velocity_scale_i[HALF_BITS-1:0]}));
    end
  end

  assign vel_full   = vel_hi_q + (vel_lo_q >>> FRAC_BITS);
  assign position_o = pos_prod_q[POS_BITS+FRAC_BITS-1:FRAC_BITS];
  assign velocity_o = vel_full[VEL_BITS-1:0];

endmodule

@@ hdl/encoder_fir_velocity_estimator_top.sv @@
// Encoder FIR velocity estimator.
// Input channel: encoder_count_i with in_valid_i / in_stall_o. One item is
// taken at an edge where in_valid_i is high and in_stall_o is low.
// Output channel: position_q16_o and velocity_q16_o with out_valid_o /
// out_stall_i, one result item per input item, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_index_i
// (0 position scale, 1 velocity scale); write only while idle.
// Sequence: an item is taken only in ST_IDLE, so a new item waits until the
// previous result is loaded: the FIR partial sum walks one cell of the
// nine-cell tap chain per cycle, then the scale products take one register
// stage and the final add another.
// Stall: a finished result holds in the output register; the block holds
// in_stall_o high until that result has moved into the output register.
// Reset: history clears to zero, both scales clear to zero, no result is
// pending. The first item after an all-zero history fills the whole history.
module encoder_fir_velocity_estimator_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [efv_pkg::COUNT_BITS-1:0]  encoder_count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [efv_pkg::POS_BITS-1:0]    position_q16_o,
  output logic signed [efv_pkg::VEL_BITS-1:0]    velocity_q16_o,
  input  logic                                   cfg_we_i,
  input  logic [efv_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [efv_pkg::SCALE_BITS-1:0]         cfg_wdata_i
);
  import efv_pkg::*;

  state_e state_q, state_d;

  logic [SCALE_BITS-1:0] position_scale_q;
  logic [SCALE_BITS-1:0] velocity_scale_q;

  logic                         accept;
  logic                         mul_en;
  logic                         out_load;
  logic                         start_q;
  logic                         all_zero;
  cell_ctrl_t                   cell_ctrl;

  logic signed [COUNT_BITS-1:0] value [TAP_COUNT];
  logic signed [COUNT_BITS-1:0] left  [TAP_COUNT];
  logic                         tok_in  [TAP_COUNT];
  logic                         tok_out [TAP_COUNT];
  logic signed [SUM_BITS-1:0]   psum_in  [TAP_COUNT];
  logic signed [SUM_BITS-1:0]   psum_out [TAP_COUNT];
  logic [TAP_COUNT-1:0]         tok_vec;
  logic [TAP_COUNT-1:0]         nz_vec;

  logic signed [POS_BITS-1:0]   position;
  logic signed [VEL_BITS-1:0]   velocity;
  logic                         out_valid_q, out_valid_d;
  logic signed [POS_BITS-1:0]   position_q;
  logic signed [VEL_BITS-1:0]   velocity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_scale_q <= '0;
      velocity_scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POSITION_SCALE: position_scale_q <= cfg_wdata_i;
        CFG_VELOCITY_SCALE: velocity_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SUM;
      ST_SUM:  if (tok_vec[TAP_COUNT-1]) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mul_en     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SUM:  ;
      ST_MUL:  mul_en = 1'b1;
      ST_OUT:  out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      nz_vec[k]  = |value[k];
      tok_vec[k] = tok_out[k];
    end
  end

  assign all_zero        = ~|nz_vec;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.fill  = all_zero;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign left[k]    = encoder_count_i;
      assign tok_in[k]  = start_q;
      assign psum_in[k] = '0;
    end else begin : g_link
      assign left[k]    = value[k-1];
      assign tok_in[k]  = tok_out[k-1];
      assign psum_in[k] = psum_out[k-1];
    end

    efv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .count_i (encoder_count_i),
      .left_i  (left[k]),
      .coef_i  (TAP_COEF[k]),
      .tok_i   (tok_in[k]),
      .psum_i  (psum_in[k]),
      .value_o (value[k]),
      .tok_o   (tok_out[k]),
      .psum_o  (psum_out[k])
    );
  end

  efv_scale u_scale (
    .clk_i            (clk_i),
    .mul_en_i         (mul_en),
    .count_i          (value[0]),
    .sum_i            (psum_out[TAP_COUNT-1]),
    .position_scale_i (position_scale_q),
    .velocity_scale_i (velocity_scale_q),
    .position_o       (position),
    .velocity_o       (velocity)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      position_q <= position;
      velocity_q <= velocity;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_q16_o = position_q;
  assign velocity_q16_o = velocity_q;

  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({start_q, tok_vec}))
    else $error("more than one partial sum in flight");

  a_tok_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || (|tok_vec)) |-> (state_q == ST_SUM))
    else $error("partial sum moving outside the sum phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(value[0]))
    else $error("history changed during computation");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import efv_pkg::*;

  typedef logic signed [COUNT_BITS-1:0] count_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [VEL_BITS-1:0]   vel_t;
  typedef logic [SCALE_BITS-1:0]        scale_t;
  typedef logic [CFG_IDX_BITS-1:0]      reg_idx_t;

  localparam reg_idx_t CFG_SPARE_A = 2'd2;
  localparam reg_idx_t CFG_SPARE_B = 2'd3;
  localparam count_t COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  // time order of a full-swing history, 1 = max count, 0 = min count
  localparam logic [TAP_COUNT-1:0] SWING = 9'b001110011;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 16;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {PAT_RANDOM, PAT_WALK, PAT_EXTREME, PAT_ZERO_RUN} pattern_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_COMB, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    row_kind_e kind;
    reg_idx_t  idx;
    scale_t    wdata;
    count_t    cnt;
    logic      pos_given;
    pos_t      pos_want;
    logic      vel_given;
    vel_t      vel_want;
  } plan_row_t;

  typedef struct packed {
    pos_t pos;
    vel_t vel;
  } motion_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  count_t   enc_count = '0;
  logic     out_stall = 1'b0;
  logic     cfg_we    = 1'b0;
  reg_idx_t cfg_idx   = '0;
  scale_t   cfg_data  = '0;
  logic     in_stall;
  logic     out_valid;
  pos_t     position;
  vel_t     velocity;

  count_t    history [TAP_COUNT];
  scale_t    pos_scale;
  scale_t    vel_scale;
  motion_t   pending_motion [$];
  plan_row_t plan [$];
  int        errors     = 0;
  int        sent       = 0;
  int        checked    = 0;
  int        reg_writes = 0;
  int        refills    = 0;
  int        idle_run   = 0;
  logic      long_hold_req = 1'b0;

  encoder_fir_velocity_estimator_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .encoder_count_i (enc_count),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .position_q16_o  (position),
    .velocity_q16_o  (velocity),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_wdata_i     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [SUM_BITS-1:0] tap_weight(input int k);
    case (k)
      0:       return SUM_BITS'(2727);
      1:       return SUM_BITS'(534);
      2:       return SUM_BITS'(-2658);
      3:       return SUM_BITS'(-795);
      4:       return SUM_BITS'(72);
      5:       return SUM_BITS'(110);
      6:       return SUM_BITS'(19);
      7:       return SUM_BITS'(-6);
      default: return SUM_BITS'(-3);
    endcase
  endfunction

  function automatic motion_t estimate_motion(input count_t cnt);
    logic signed [SUM_BITS-1:0] fir_sum;
    logic signed [95:0] prod;
    logic signed [95:0] shifted;
    logic flat;
    motion_t m;
    flat = 1'b1;
    for (int k = 0; k < TAP_COUNT; k++) begin
      if (history[k] != '0) flat = 1'b0;
    end
    // start from a flat history so the derivative sees no step
    if (flat) begin
      if (cnt != '0) refills++;
      for (int k = 0; k < TAP_COUNT; k++) history[k] = cnt;
    end
    for (int k = TAP_COUNT - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = cnt;
    fir_sum = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      fir_sum = fir_sum + SUM_BITS'(history[k]) * tap_weight(k);
    end
    prod    = 96'(cnt) * $signed({64'd0, pos_scale});
    shifted = prod >>> FRAC_BITS;
    m.pos   = shifted[POS_BITS-1:0];
    prod    = 96'(fir_sum) * $signed({64'd0, vel_scale});
    shifted = prod >>> FRAC_BITS;
    m.vel   = shifted[VEL_BITS-1:0];
    return m;
  endfunction

  function automatic scale_t pick_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SCALE_BITS'(1);
      3:       return {1'b1, {(SCALE_BITS-1){1'b0}}};
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_item(input count_t cnt, input logic pg, input pos_t pw,
                                   input logic vg, input vel_t vw);
    plan_row_t row;
    row           = '0;
    row.kind      = ROW_ITEM;
    row.cnt       = cnt;
    row.pos_given = pg;
    row.pos_want  = pw;
    row.vel_given = vg;
    row.vel_want  = vw;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input reg_idx_t idx, input scale_t val);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.wdata = val;
    plan.push_back(row);
  endfunction

  task automatic send_item(input count_t cnt, input logic pos_given, input pos_t pos_want,
                           input logic vel_given, input vel_t vel_want);
    motion_t m;
    in_valid  <= 1'b1;
    enc_count <= cnt;
    do @(posedge clk); while (in_stall);
    m = estimate_motion(cnt);
    if (pos_given) m.pos = pos_want;
    if (vel_given) m.vel = vel_want;
    pending_motion.push_back(m);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_motion.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input scale_t val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POSITION_SCALE) pos_scale = val;
    else if (idx == CFG_VELOCITY_SCALE) vel_scale = val;
    reg_writes++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    pattern_e  pat;
    plan_row_t row;
    count_t    cnt;
    logic [31:0] r;
    int burst;
    int gap;
    int left;
    int delta;
    int walk;
    for (int k = 0; k < TAP_COUNT; k++) history[k] = '0;
    pos_scale = '0;
    vel_scale = '0;

    // scales are zero out of reset
    add_item('0, 1'b1, '0, 1'b1, '0);
    add_item(COUNT_MAX, 1'b1, '0, 1'b1, '0);
    add_item(COUNT_MIN, 1'b1, '0, 1'b1, '0);
    // unit scale: position equals the count
    add_cfg(CFG_POSITION_SCALE, 32'h0001_0000);
    add_cfg(CFG_VELOCITY_SCALE, 32'h0001_0000);
    add_item(COUNT_MAX, 1'b1, POS_BITS'(COUNT_MAX), 1'b0, '0);
    add_item(COUNT_MIN, 1'b1, POS_BITS'(COUNT_MIN), 1'b0, '0);
    add_cfg(CFG_POSITION_SCALE, '1);
    add_cfg(CFG_VELOCITY_SCALE, '1);
    add_cfg(CFG_SPARE_A, '0);
    add_cfg(CFG_SPARE_B, 32'h1234_5678);
    for (int i = TAP_COUNT - 1; i >= 0; i--) begin
      add_item(SWING[i] ? COUNT_MAX : COUNT_MIN, 1'b0, '0, 1'b0, '0);
    end
    for (int i = 0; i < TAP_COUNT; i++) add_item('0, 1'b0, '0, 1'b0, '0);
    // flat history again: refill leaves no velocity
    add_item(COUNT_BITS'(5), 1'b0, '0, 1'b1, '0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.idx, row.wdata);
      end else begin
        send_item(row.cnt, row.pos_given, row.pos_want, row.vel_given, row.vel_want);
      end
    end

    walk = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_POSITION_SCALE, pick_scale());
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_VELOCITY_SCALE, pick_scale());
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
      end
      if (ph == 3) long_hold_req = 1'b1;
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        pat   = pattern_e'($urandom_range(0, 3));
        burst = (pat == PAT_ZERO_RUN) ? $urandom_range(9, 12) : $urandom_range(1, 30);
        if (burst > left) burst = left;
        for (int b = 0; b < burst; b++) begin
          case (pat)
            PAT_RANDOM: begin
              r   = $urandom();
              cnt = r[COUNT_BITS-1:0];
            end
            PAT_WALK: begin
              if ($urandom_range(0, 7) == 0) delta = int'($urandom_range(0, 8192)) - 4096;
              else delta = int'($urandom_range(0, 128)) - 64;
              walk = walk + delta;
              cnt  = walk[COUNT_BITS-1:0];
            end
            PAT_EXTREME: begin
              case ($urandom_range(0, 4))
                0:       cnt = COUNT_MAX;
                1:       cnt = COUNT_MIN;
                2:       cnt = '0;
                3:       cnt = '1;
                default: cnt = COUNT_BITS'(1);
              endcase
            end
            default: cnt = '0;
          endcase
          send_item(cnt, 1'b0, '0, 1'b0, '0);
          left--;
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          gap = $urandom_range(1, 15);
          repeat (gap) @(negedge clk);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d encoder counts sent, %0d results compared, %0d register writes",
             sent, checked, reg_writes);
    $display("%0d history refills from a flat zero history, %0d mismatches", refills, errors);
    if (errors == 0) begin
      $display("encoder_fir_velocity_estimator_top regression: pass");
    end else begin
      $display("encoder_fir_velocity_estimator_top regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    stall_mode_e mode;
    int seg;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(10, 120);
      for (int k = 0; k < seg; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_COMB:  out_stall <= ((k % 5) < 2);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    motion_t want;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_run);
      $display("encoder_fir_velocity_estimator_top regression: fail");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_motion.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, position %0d velocity %0d",
                 $time, position, velocity);
      end else begin
        want = pending_motion.pop_front();
        checked++;
        if (position !== want.pos) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
        end
        if (velocity !== want.vel) begin
          errors++;
          $display("%0t: velocity expected %0d actual %0d", $time, want.vel, velocity);
        end
      end
    end
  end

endmodule

@@ files.f @@
hdl/efv_pkg.sv
hdl/efv_cell.sv
hdl/efv_scale.sv
hdl/encoder_fir_velocity_estimator_top.sv
test/tb.sv
